FILE: hdl/vectored_interrupt_controller_macros.svh
// Assertion macros shared by the interrupt controller RTL.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef VECTORED_INTERRUPT_CONTROLLER_MACROS_SVH
`define VECTORED_INTERRUPT_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define VIC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interrupt controller check failed");

// Next-cycle implication, disabled while reset is low
`define VIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interrupt controller check failed");

`endif

FILE: hdl/vic_pkg.sv
// Shared types and constants of the vectored interrupt controller.
// No dependencies; imported by vic_lowest and the top level.
package vic_pkg;

    localparam int NUM_VECTORS_DEF = 64;

    // Payload widths
    localparam int VEC_W    = 6;
    localparam int STRIDE_W = 4;
    localparam int ADDR_W   = 9;
    localparam int PC_W     = 16;
    localparam int RET_W    = 15;
    localparam int LAT_W    = 4;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_STRIDE_ADDR = 3'd0;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 4'd4;
    localparam logic [STRIDE_W-1:0] STRIDE_MAX   = 4'd8;

    // Latency counter
    localparam logic [LAT_W-1:0] LATENCY_RELOAD = 4'd2;
    localparam logic [LAT_W-1:0] LATENCY_MAX    = 4'd15;
    localparam logic [LAT_W-1:0] LATENCY_ONE    = 4'd1;

    typedef enum logic [0:0] {
        MODE_RAISE = 1'b0,
        MODE_CYCLE = 1'b1
    } t_mode;

endpackage

FILE: hdl/vic_lowest.sv
// Lowest-set-bit encoder over the pending vector flags.
// Depends on vic_pkg for the vector number width.
module vic_lowest import vic_pkg::*; #(
    parameter int NUM_VECTORS = NUM_VECTORS_DEF
) (
    input  logic [NUM_VECTORS-1:0] i_bits,
    output logic [VEC_W-1:0]       o_index
);

    logic [NUM_VECTORS-1:0] w_isolated;

    // Keep only the lowest set bit
    assign w_isolated = i_bits & (~i_bits + {{(NUM_VECTORS-1){1'b0}}, 1'b1});

    // Encode the one-hot flag into its number
    always_comb begin
        o_index = '0;
        for (int k = 0; k < NUM_VECTORS; k++) begin
            if (w_isolated[k]) begin
                o_index = o_index | VEC_W'(k);
            end
        end
    end

endmodule

FILE: hdl/vectored_interrupt_controller.sv
// Vectored interrupt controller top level: request register, pending/latency state,
// result register and APB register. Depends on vic_pkg, vic_lowest and the macro header.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one request per cycle while o_ready is high:
//   either a raise of a vector (mode 0) or one CPU cycle service step (mode 1). Every
//   request gives exactly one result on the output channel (o_valid/i_ready).
//   An accepted request is held in the request register; its result is then written
//   to the result register. Throughput: one request per cycle when the receiver takes
//   each result; the whole update, including the lowest-pending search and the 6x4
//   address multiply, sits between the two registers.
//   When the receiver stalls, the result register holds and the request register fills;
//   o_ready then drops until the result is taken. Nothing is lost or repeated.
//   Reset clears the pending flags, the latency counter and both valid flags, and sets
//   the vector stride to 4. The stride register sits at APB byte address 0, is written
//   in the access phase and must only be changed while no request is in flight.
`include "vectored_interrupt_controller_macros.svh"

module vectored_interrupt_controller import vic_pkg::*; #(
    parameter int NUM_VECTORS = NUM_VECTORS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic [VEC_W-1:0]      i_vector_number,
    input  logic                  i_vector_enabled,
    input  logic                  i_global_enable,
    input  logic                  i_reenabled,
    input  logic                  i_cpu_awake,
    input  logic [PC_W-1:0]       i_current_pc,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_raise_accepted,
    output logic                  o_set_raised_flag,
    output logic                  o_wake_cpu,
    output logic                  o_take_interrupt,
    output logic [VEC_W-1:0]      o_taken_vector,
    output logic [ADDR_W-1:0]     o_vector_address,
    output logic [RET_W-1:0]      o_return_word,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
    localparam logic [VEC_W:0] NUM_LIMIT = (VEC_W+1)'(NUM_VECTORS);
    localparam int PROD_W = VEC_W + STRIDE_W;

    // Request register
    logic                   r_in_valid;
    t_mode                  r_mode;
    logic [VEC_W-1:0]       r_vnum;
    logic                   r_ven;
    logic                   r_gie;
    logic                   r_reen;
    logic                   r_awake;
    logic [PC_W-1:0]        r_pc;

    // Controller state
    logic [NUM_VECTORS-1:0] r_pending;
    logic [NUM_VECTORS-1:0] n_pending;
    logic [LAT_W-1:0]       r_latency;
    logic [LAT_W-1:0]       n_latency;
    logic [STRIDE_W-1:0]    r_stride;

    // Result register
    logic                   r_out_valid;
    logic                   r_raise_accepted;
    logic                   r_set_raised;
    logic                   r_wake;
    logic                   r_take;
    logic [VEC_W-1:0]       r_taken_vector;
    logic [ADDR_W-1:0]      r_vector_address;
    logic [RET_W-1:0]       r_return_word;

    // Next-state logic
    logic                   w_advance;
    logic                   w_in_range;
    logic [IDX_W-1:0]       w_raise_idx;
    logic [VEC_W-1:0]       w_lowest;
    logic [IDX_W-1:0]       w_lowest_idx;
    logic [STRIDE_W-1:0]    w_stride;
    logic [PROD_W-1:0]      w_product;
    logic [LAT_W-1:0]       w_lat_inc;
    logic                   w_cfg_write;
    logic                   n_raise_accepted;
    logic                   n_set_raised;
    logic                   n_wake;
    logic                   n_take;

    // Handshake: move the request on whenever the result register is free or being taken
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    // Capture request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_mode  <= t_mode'(i_mode);
            r_vnum  <= i_vector_number;
            r_ven   <= i_vector_enabled;
            r_gie   <= i_global_enable;
            r_reen  <= i_reenabled;
            r_awake <= i_cpu_awake;
            r_pc    <= i_current_pc;
        end
    end

    // Lowest pending vector
    vic_lowest #(
        .NUM_VECTORS(NUM_VECTORS)
    ) u_lowest (
        .i_bits (r_pending),
        .o_index(w_lowest)
    );

    assign w_lowest_idx = w_lowest[IDX_W-1:0];
    assign w_in_range   = ({1'b0, r_vnum} < NUM_LIMIT);
    assign w_raise_idx  = r_vnum[IDX_W-1:0];

    // Vector address: clamp stride, then multiply
    assign w_stride  = (r_stride > STRIDE_MAX) ? STRIDE_MAX : r_stride;
    assign w_product = PROD_W'(w_lowest) * PROD_W'(w_stride);

    // Saturating bump when interrupts were just re-enabled
    assign w_lat_inc = (r_reen && (r_latency != LATENCY_MAX)) ? (r_latency + LATENCY_ONE)
                                                             : r_latency;

    // Raise and service step
    always_comb begin
        n_pending        = r_pending;
        n_latency        = r_latency;
        n_raise_accepted = 1'b0;
        n_set_raised     = 1'b0;
        n_wake           = 1'b0;
        n_take           = 1'b0;
        case (r_mode)
            MODE_RAISE: begin
                if (w_in_range && (r_vnum != '0)) begin
                    n_set_raised = 1'b1;
                    if (r_ven) begin
                        n_raise_accepted = 1'b1;
                        if (!r_pending[w_raise_idx]) begin
                            if (r_latency == '0) begin
                                n_latency = LATENCY_RELOAD;
                            end
                            n_pending[w_raise_idx] = 1'b1;
                            n_wake = !r_awake;
                        end
                    end
                end
            end
            MODE_CYCLE: begin
                n_latency = w_lat_inc;
                if (r_gie && (|r_pending)) begin
                    if (w_lat_inc == '0) begin
                        n_latency = LATENCY_RELOAD;
                    end else begin
                        n_latency = w_lat_inc - LATENCY_ONE;
                        if (w_lat_inc == LATENCY_ONE) begin
                            n_take = 1'b1;
                            n_pending[w_lowest_idx] = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Advance state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_latency   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_pending <= n_pending;
                r_latency <= n_latency;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_advance) begin
            r_raise_accepted <= n_raise_accepted;
            r_set_raised     <= n_set_raised;
            r_wake           <= n_wake;
            r_take           <= n_take;
            r_taken_vector   <= n_take ? w_lowest : '0;
            r_vector_address <= n_take ? w_product[ADDR_W-1:0] : '0;
            r_return_word    <= n_take ? r_pc[PC_W-1:1] : '0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_raise_accepted  = r_raise_accepted;
    assign o_set_raised_flag = r_set_raised;
    assign o_wake_cpu        = r_wake;
    assign o_take_interrupt  = r_take;
    assign o_taken_vector    = r_taken_vector;
    assign o_vector_address  = r_vector_address;
    assign o_return_word     = r_return_word;

    // Configuration register
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && (paddr == REG_STRIDE_ADDR);
    assign prdata      = (paddr == REG_STRIDE_ADDR) ? CFG_DATA_W'(r_stride) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
        end else if (w_cfg_write) begin
            r_stride <= pwdata[STRIDE_W-1:0];
        end
    end

    // Checks
    `VIC_ASSERT_NEXT(a_taken_cleared, i_clk, i_rst_n, w_advance && n_take, !r_pending[$past(w_lowest_idx)])
    `VIC_ASSERT_NEXT(a_take_at_zero, i_clk, i_rst_n, w_advance && n_take, r_latency == '0)
    `VIC_ASSERT_IMP(a_wake_needs_raise, i_clk, i_rst_n, r_out_valid && r_wake, r_raise_accepted && !r_take)

endmodule

FILE: bench/tb_vectored_interrupt_controller.sv
// Self-checking bench for the vectored interrupt controller: raises, service steps,
// stride register and back-pressure. Depends on vic_pkg and the controller RTL.
`timescale 1ns / 100ps

module tb_vectored_interrupt_controller;
    import vic_pkg::*;

    localparam int CLK_HALF_NS  = 10;
    localparam int RESET_CYCLES = 11;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 6;
    localparam int TIMEOUT_NS   = 20_000_000;
    localparam int LOWEST_WIDE  = 63;

    typedef enum logic {
        READY_ALWAYS,
        READY_PATTERN
    } t_ready_style;

    typedef struct {
        t_mode            mode;
        logic [VEC_W-1:0] vector_number;
        logic             vector_enabled;
        logic             global_enable;
        logic             reenabled;
        logic             cpu_awake;
        logic [PC_W-1:0]  current_pc;
    } t_irq_request;

    typedef struct {
        logic              raise_accepted;
        logic              set_raised_flag;
        logic              wake_cpu;
        logic              take_interrupt;
        logic [VEC_W-1:0]  taken_vector;
        logic [ADDR_W-1:0] vector_address;
        logic [RET_W-1:0]  return_word;
    } t_irq_outcome;

    // Clock, reset and block inputs, all known from time zero
    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_valid          = 1'b0;
    logic                  i_mode           = MODE_RAISE;
    logic [VEC_W-1:0]      i_vector_number  = '0;
    logic                  i_vector_enabled = 1'b0;
    logic                  i_global_enable  = 1'b0;
    logic                  i_reenabled      = 1'b0;
    logic                  i_cpu_awake      = 1'b0;
    logic [PC_W-1:0]       i_current_pc     = '0;
    logic                  i_ready          = 1'b0;
    logic                  psel             = 1'b0;
    logic                  penable          = 1'b0;
    logic                  pwrite           = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr            = '0;
    logic [CFG_DATA_W-1:0] pwdata           = '0;

    logic                  o_ready;
    logic                  o_valid;
    logic                  o_raise_accepted;
    logic                  o_set_raised_flag;
    logic                  o_wake_cpu;
    logic                  o_take_interrupt;
    logic [VEC_W-1:0]      o_taken_vector;
    logic [ADDR_W-1:0]     o_vector_address;
    logic [RET_W-1:0]      o_return_word;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state
    logic [NUM_VECTORS_DEF-1:0] pending_mask = '0;
    logic [LAT_W-1:0]           latency_cnt  = '0;
    logic [STRIDE_W-1:0]        stride_reg   = STRIDE_RESET;
    t_irq_outcome               outcome_q[$];

    // Bookkeeping
    int unsigned  error_count   = 0;
    int unsigned  result_count  = 0;
    int unsigned  sent_count    = 0;
    int unsigned  taken_count   = 0;
    int unsigned  wake_count    = 0;
    int unsigned  burst_left    = 1;
    bit           gaps_enabled  = 1'b1;
    t_ready_style ready_style   = READY_PATTERN;
    int unsigned  hold_requests = 0;
    int unsigned  hold_served   = 0;
    int unsigned  hold_left     = 0;
    logic [15:0]  stall_pattern = 16'hA5F3;
    int unsigned  pattern_pos   = 0;

    vectored_interrupt_controller u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_vector_number  (i_vector_number),
        .i_vector_enabled (i_vector_enabled),
        .i_global_enable  (i_global_enable),
        .i_reenabled      (i_reenabled),
        .i_cpu_awake      (i_cpu_awake),
        .i_current_pc     (i_current_pc),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_raise_accepted (o_raise_accepted),
        .o_set_raised_flag(o_set_raised_flag),
        .o_wake_cpu       (o_wake_cpu),
        .o_take_interrupt (o_take_interrupt),
        .o_taken_vector   (o_taken_vector),
        .o_vector_address (o_vector_address),
        .o_return_word    (o_return_word),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Generate the clock
    always begin
        #(CLK_HALF_NS) i_clk = 1'b1;
        #(CLK_HALF_NS) i_clk = 1'b0;
    end

    // Update pending flags and latency counter for one request, return its outcome
    function automatic t_irq_outcome predict_outcome(t_irq_request rq);
        t_irq_outcome res;
        int           v;
        int           eff_stride;
        res = '{default: '0};
        if (rq.mode == MODE_RAISE) begin
            if (rq.vector_number != 0) begin
                res.set_raised_flag = 1'b1;
                if (rq.vector_enabled) begin
                    res.raise_accepted = 1'b1;
                    if (!pending_mask[rq.vector_number]) begin
                        if (latency_cnt == 0)
                            latency_cnt = LATENCY_RELOAD;
                        pending_mask[rq.vector_number] = 1'b1;
                        res.wake_cpu = !rq.cpu_awake;
                    end
                end
            end
        end else begin
            if (rq.reenabled && latency_cnt < LATENCY_MAX)
                latency_cnt = latency_cnt + 1'b1;
            if (rq.global_enable && pending_mask != 0) begin
                if (latency_cnt == 0) begin
                    // empty counter with work waiting: reload instead of taking
                    latency_cnt = LATENCY_RELOAD;
                end else begin
                    latency_cnt = latency_cnt - 1'b1;
                    if (latency_cnt == 0) begin
                        v = 0;
                        while (v < LOWEST_WIDE && !pending_mask[v])
                            v++;
                        pending_mask[v] = 1'b0;
                        eff_stride = (stride_reg > STRIDE_MAX) ? STRIDE_MAX : stride_reg;
                        res.take_interrupt = 1'b1;
                        res.taken_vector   = VEC_W'(v);
                        res.vector_address = ADDR_W'(v * eff_stride);
                        res.return_word    = rq.current_pc[PC_W-1:1];
                    end
                end
            end
        end
        if (res.take_interrupt)
            taken_count++;
        if (res.wake_cpu)
            wake_count++;
        return res;
    endfunction

    function automatic t_irq_request make_request(t_mode mode, int vec, bit en, bit gie,
                                                  bit reen, bit awake, int pc);
        t_irq_request rq;
        rq.mode           = mode;
        rq.vector_number  = VEC_W'(vec);
        rq.vector_enabled = en;
        rq.global_enable  = gie;
        rq.reenabled      = reen;
        rq.cpu_awake      = awake;
        rq.current_pc     = PC_W'(pc);
        return rq;
    endfunction

    // Draw a request; low vectors are favoured so that raises collide with pending ones
    function automatic t_irq_request random_request(int raise_pct, int gie_pct, int reen_pct);
        t_irq_request rq;
        int           pick;
        rq.mode = ($urandom_range(99) < raise_pct) ? MODE_RAISE : MODE_CYCLE;
        pick = $urandom_range(99);
        if (pick < 5)
            rq.vector_number = '0;
        else if (pick < 55)
            rq.vector_number = VEC_W'($urandom_range(1, 7));
        else
            rq.vector_number = VEC_W'($urandom_range(63));
        rq.vector_enabled = ($urandom_range(99) < 85);
        rq.global_enable  = ($urandom_range(99) < gie_pct);
        rq.reenabled      = ($urandom_range(99) < reen_pct);
        rq.cpu_awake      = 1'($urandom_range(1));
        rq.current_pc     = PC_W'($urandom);
        return rq;
    endfunction

    // Offer one request, hold it until accepted, then maybe leave a gap
    task automatic offer_request(t_irq_request rq);
        int unsigned gap;
        i_valid          <= 1'b1;
        i_mode           <= rq.mode;
        i_vector_number  <= rq.vector_number;
        i_vector_enabled <= rq.vector_enabled;
        i_global_enable  <= rq.global_enable;
        i_reenabled      <= rq.reenabled;
        i_cpu_awake      <= rq.cpu_awake;
        i_current_pc     <= rq.current_pc;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        outcome_q.push_back(predict_outcome(rq));
        sent_count++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 7);
            if (gaps_enabled && gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid and wait until every outcome has come out
    task automatic settle_block();
        i_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the stride register while idle, then read it back
    task automatic program_stride(logic [STRIDE_W-1:0] value);
        settle_block();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_STRIDE_ADDR;
        pwdata  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        stride_reg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[STRIDE_W-1:0] !== value) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("stride read-back: expected %0h, got %0h", value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%s mismatch on result %0d: expected %0h, got %0h",
                         name, result_count, exp_v, act_v);
        end
    endtask

    // Check each accepted result against the oldest outcome
    always @(posedge i_clk) begin : check_results
        t_irq_outcome exp_o;
        if (i_rst_n && o_valid && i_ready) begin
            if (outcome_q.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("result %0d arrived with nothing outstanding", result_count);
            end else begin
                exp_o = outcome_q.pop_front();
                compare_field("raise_accepted", exp_o.raise_accepted, o_raise_accepted);
                compare_field("set_raised_flag", exp_o.set_raised_flag, o_set_raised_flag);
                compare_field("wake_cpu", exp_o.wake_cpu, o_wake_cpu);
                compare_field("take_interrupt", exp_o.take_interrupt, o_take_interrupt);
                compare_field("taken_vector", exp_o.taken_vector, o_taken_vector);
                compare_field("vector_address", exp_o.vector_address, o_vector_address);
                compare_field("return_word", exp_o.return_word, o_return_word);
            end
            result_count++;
        end
    end

    // Drive result-side ready: long hold when asked, else always ready or a rotating stall pattern
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            i_ready     <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (ready_style == READY_ALWAYS) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= stall_pattern[pattern_pos];
            if (pattern_pos == 15) begin
                pattern_pos   <= 0;
                stall_pattern <= 16'($urandom) | 16'h0411;
            end else begin
                pattern_pos <= pattern_pos + 1;
            end
        end
    end

    // Directed cases at the reset stride: ignore, flag only, wake, take, reload
    task automatic test_directed_cases();
        offer_request(make_request(MODE_RAISE, 0, 1, 1, 0, 0, 16'hFFFF));
        offer_request(make_request(MODE_RAISE, 1, 0, 0, 1, 0, 0));
        offer_request(make_request(MODE_RAISE, 63, 1, 0, 0, 0, 0));
        offer_request(make_request(MODE_RAISE, 63, 1, 1, 1, 0, 16'hFFFF));
        offer_request(make_request(MODE_RAISE, 1, 1, 0, 0, 1, 0));
        offer_request(make_request(MODE_CYCLE, 5, 1, 0, 0, 1, 16'hFFFF));
        offer_request(make_request(MODE_CYCLE, 0, 0, 1, 0, 0, 16'hFFFF));
        offer_request(make_request(MODE_CYCLE, 0, 0, 1, 0, 0, 16'hFFFF));
        offer_request(make_request(MODE_CYCLE, 0, 0, 1, 0, 0, 0));
        offer_request(make_request(MODE_CYCLE, 0, 0, 1, 1, 0, 16'h1234));
        offer_request(make_request(MODE_CYCLE, 0, 0, 1, 0, 0, 16'h0001));
        offer_request(make_request(MODE_CYCLE, 0, 0, 1, 0, 0, 0));
        offer_request(make_request(MODE_CYCLE, 63, 1, 1, 1, 1, 16'hAAAA));
        offer_request(make_request(MODE_RAISE, 2, 1, 1, 0, 0, 16'h5555));
        offer_request(make_request(MODE_CYCLE, 0, 0, 1, 0, 1, 16'h7FFE));
        offer_request(make_request(MODE_CYCLE, 0, 0, 1, 0, 1, 16'h8001));
    endtask

    // Random traffic across the stride extremes and a few values between
    task automatic test_stride_range();
        logic [STRIDE_W-1:0] strides[6];
        strides = '{4'd0, 4'd1, STRIDE_MAX, 4'd15, 4'($urandom_range(2, 7)), 4'd9};
        foreach (strides[s]) begin
            program_stride(strides[s]);
            repeat (50) offer_request(random_request(40, 80, 20));
        end
    endtask

    // Push the counter up to saturation, then let the vectors drain
    task automatic test_counter_saturation();
        program_stride(4'($urandom_range(16)));
        repeat (50) offer_request(random_request(5, 10, 95));
        repeat (30) offer_request(random_request(20, 95, 10));
    endtask

    // Hold the receiver off while the sender keeps offering, so the block stalls its input
    task automatic test_receiver_hold();
        ready_style  = READY_PATTERN;
        gaps_enabled = 1'b0;
        hold_requests++;
        repeat (60) offer_request(random_request(40, 80, 20));
        gaps_enabled = 1'b1;
    endtask

    // Run back to back with no idling on either side
    task automatic test_steady_stream();
        settle_block();
        ready_style  = READY_ALWAYS;
        gaps_enabled = 1'b0;
        repeat (60) offer_request(random_request(45, 85, 15));
        gaps_enabled = 1'b1;
        ready_style  = READY_PATTERN;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_stride_range();
        test_counter_saturation();
        test_receiver_hold();
        test_steady_stream();
        program_stride(STRIDE_RESET);
        repeat (20) offer_request(random_request(40, 80, 20));

        settle_block();
        $display("Sent %0d requests, checked %0d results: %0d interrupts taken, %0d wakes.",
                 sent_count, result_count, taken_count, wake_count);
        $display("Strides 0 to 15 incl. extremes, counter saturation, %0d-cycle receiver hold.",
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d outcomes outstanding", outcome_q.size());
        $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/vic_pkg.sv
hdl/vic_lowest.sv
hdl/vectored_interrupt_controller.sv
bench/tb_vectored_interrupt_controller.sv
